// File: rtl/core/qkb_pkg.sv
// Shared types and constants for the quadrature knob with button block.
// No dependencies; imported by every module under rtl/core.
package qkb_pkg;

  // Register indexes on the configuration port (byte address bit 2)
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  localparam logic [7:0]  DEBOUNCE_RESET   = 8'd5;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd100;

  // Accumulator limits for one detent
  localparam logic signed [3:0] ACC_CW_LIMIT  = 4'sd4;
  localparam logic signed [3:0] ACC_CCW_LIMIT = -4'sd4;

  // Step per transition, indexed by {previous_phase, current_phase}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

  // Event bits, same order as the pending word: long, short, ccw, cw
  typedef struct packed {
    logic long_p;
    logic short_p;
    logic ccw;
    logic cw;
  } qkb_evt_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
  } qkb_cfg_t;

endpackage

// File: rtl/core/qkb_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on qkb_pkg.
module qkb_cfg
  import qkb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output qkb_cfg_t    cfg
);

  logic [7:0]  debounce_r,   debounce_nxt;
  logic [15:0] long_press_r, long_press_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    debounce_nxt   = debounce_r;
    long_press_nxt = long_press_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_DEBOUNCE:   debounce_nxt   = cfg_pwdata[7:0];
        REG_LONG_PRESS: long_press_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DEBOUNCE:   cfg_prdata = {24'd0, debounce_r};
      REG_LONG_PRESS: cfg_prdata = {16'd0, long_press_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else begin
      debounce_r   <= debounce_nxt;
      long_press_r <= long_press_nxt;
    end
  end

  assign cfg.debounce_ticks   = debounce_r;
  assign cfg.long_press_ticks = long_press_r;

endmodule

// File: rtl/core/qkb_rotary.sv
// Quadrature phase decoder: transition lookup and detent accumulator.
// Depends on qkb_pkg (STEP_TABLE, qkb_evt_t).
module qkb_rotary
  import qkb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     tick,
  input  logic     primed,
  input  logic     phase_a,
  input  logic     phase_b,
  output qkb_evt_t evt
);

  logic [1:0]        prev_r, prev_nxt;
  logic signed [3:0] acc_r,  acc_nxt;
  logic [1:0]        phase;
  logic signed [1:0] step;
  logic signed [3:0] sum;

  assign phase = {phase_b, phase_a};
  assign step  = STEP_TABLE[{prev_r, phase}];
  assign sum   = acc_r + 4'(step);

  always_comb begin
    prev_nxt = prev_r;
    acc_nxt  = acc_r;
    evt      = '0;
    if (tick) begin
      prev_nxt = phase;
      if (primed && step != 2'sd0) begin
        acc_nxt = sum;
        if (sum >= ACC_CW_LIMIT) begin
          evt.cw  = 1'b1;
          acc_nxt = 4'sd0;
        end else if (sum <= ACC_CCW_LIMIT) begin
          evt.ccw = 1'b1;
          acc_nxt = 4'sd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 2'd0;
      acc_r  <= 4'sd0;
    end else begin
      prev_r <= prev_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// File: rtl/core/qkb_switch.sv
// Push switch debounce and long-press hold counter.
// Depends on qkb_pkg (qkb_cfg_t, qkb_evt_t).
module qkb_switch
  import qkb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     tick,
  input  logic     primed,
  input  logic     switch_level,
  input  qkb_cfg_t cfg,
  output qkb_evt_t evt
);

  logic        raw_r,    raw_nxt;
  logic        stable_r, stable_nxt;
  logic [7:0]  deb_r,    deb_nxt;
  logic [15:0] hold_r,   hold_nxt;
  logic        lr_r,     lr_nxt;
  logic        pressed;
  logic [7:0]  deb_inc;
  logic [15:0] hold_inc;

  assign pressed  = !switch_level;
  assign deb_inc  = deb_r + 8'd1;
  assign hold_inc = (hold_r < cfg.long_press_ticks) ? hold_r + 16'd1 : hold_r;

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    deb_nxt    = deb_r;
    hold_nxt   = hold_r;
    lr_nxt     = lr_r;
    evt        = '0;
    if (tick) begin
      if (!primed) begin
        raw_nxt    = pressed;
        stable_nxt = pressed;
        deb_nxt    = 8'd0;
        hold_nxt   = 16'd0;
        lr_nxt     = 1'b0;
      end else if (pressed != raw_r) begin
        raw_nxt = pressed;
        deb_nxt = 8'd0;
      end else if (deb_r < cfg.debounce_ticks) begin
        deb_nxt = deb_inc;
        if (deb_inc >= cfg.debounce_ticks && stable_r != raw_r) begin
          stable_nxt = raw_r;
          if (raw_r) begin
            hold_nxt = 16'd0;
            lr_nxt   = 1'b0;
          end else if (!lr_r) begin
            evt.short_p = 1'b1;
          end
        end
      end else if (stable_r && !lr_r) begin
        // settled press: count toward the long-press threshold
        hold_nxt = hold_inc;
        if (hold_inc >= cfg.long_press_ticks) begin
          evt.long_p = 1'b1;
          lr_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      deb_r    <= 8'd0;
      hold_r   <= 16'd0;
      lr_r     <= 1'b0;
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      deb_r    <= deb_nxt;
      hold_r   <= hold_nxt;
      lr_r     <= lr_nxt;
    end
  end

endmodule

// File: rtl/core/quadrature_knob_with_button.sv
// Top level of the quadrature knob with debounced push button.
// Depends on qkb_pkg, qkb_cfg, qkb_rotary and qkb_switch.

// Each request on the in_ channel is one poll tick of the knob pins: the A/B
// phases, the active-low switch level, and func (1 = report and clear the
// pending events). Every request yields exactly one result on the out_
// channel with the events pending after that tick, and taken = func. The
// first tick after reset only captures the pins. A detent is four valid
// phase steps in one direction; a press needs debounce_ticks equal samples
// to settle, and a long press fires after long_press_ticks further ticks of
// a settled press (no short press is then reported on release). Decode runs
// in single-pass logic between the running state and the result register,
// so a request can be accepted in every cycle in which in_stall is low.
// in_stall rises only while a result is held by out_stall.
// Registers: 0x0 debounce_ticks (8 bit, reset 5), 0x4 long_press_ticks
// (16 bit, reset 100). Write them only while the block is idle.
module quadrature_knob_with_button
  import qkb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic        in_phase_a,
  input  logic        in_phase_b,
  input  logic        in_switch_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_turned_cw,
  output logic        out_turned_ccw,
  output logic        out_short_press,
  output logic        out_long_press,
  output logic        out_taken,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  qkb_cfg_t cfg;
  qkb_evt_t rot_evt, sw_evt, ev_now;
  qkb_evt_t pending_r, pending_nxt;
  qkb_evt_t res_r, res_nxt;
  logic     primed_r, primed_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     taken_r, taken_nxt;
  logic     tick;

  // Result register frees up when empty or drained in this cycle
  assign in_stall = out_valid_r && out_stall;
  assign tick     = in_valid && !in_stall;

  qkb_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  qkb_rotary u_rotary (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick),
    .primed (primed_r),
    .phase_a(in_phase_a),
    .phase_b(in_phase_b),
    .evt    (rot_evt)
  );

  qkb_switch u_switch (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .primed      (primed_r),
    .switch_level(in_switch_level),
    .cfg         (cfg),
    .evt         (sw_evt)
  );

  // Sticky events: new ones merge in, a take clears after reporting
  assign ev_now = pending_r | rot_evt | sw_evt;

  always_comb begin
    primed_nxt    = primed_r;
    pending_nxt   = pending_r;
    res_nxt       = res_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (tick) begin
      primed_nxt    = 1'b1;
      pending_nxt   = in_func ? qkb_evt_t'('0) : ev_now;
      res_nxt       = ev_now;
      taken_nxt     = in_func;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      primed_r    <= primed_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    taken_r <= taken_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_turned_cw   = res_r.cw;
  assign out_turned_ccw  = res_r.ccw;
  assign out_short_press = res_r.short_p;
  assign out_long_press  = res_r.long_p;
  assign out_taken       = taken_r;

  // A take leaves nothing pending
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && in_func) |=> (pending_r == qkb_evt_t'('0)))
    else $error("pending events survived a take");

  // Without a take no pending event is lost
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(tick && in_func)) |=> ((pending_r & $past(pending_r)) == $past(pending_r)))
    else $error("pending event dropped without a take");

  // Each request yields a result that reports its func as taken
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (out_valid && (out_taken == $past(in_func))))
    else $error("result missing or taken flag wrong");

  // Result reports everything that was pending before the tick
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> ((res_r & $past(pending_r)) == $past(pending_r)))
    else $error("pending event not reported");

endmodule
